FILE: hw/rtl/snorm_pkg.sv
`timescale 1ns / 1ps
package snorm_pkg;

  // Field formats: positions are signed Q10.10, unit vectors signed Q1.14.
  localparam int COORD_BITS = 20;
  localparam int UNIT_BITS  = 16;
  localparam int UNIT_FRAC  = UNIT_BITS - 2;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int ROOT_W     = 63;
  localparam int SQRT_CELLS = 31;
  localparam int DIV_W      = 47;
  localparam int QUO_BITS   = 16;

  // Object kinds; every other code takes the cylinder path.
  localparam logic [1:0] KIND_PLANE  = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;

  typedef struct packed {
    logic [1:0]  object_kind;
    logic [59:0] hit_point;
    logic [59:0] object_center;
    logic [47:0] object_axis;
    logic [47:0] ray_dir;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               flipped;
    logic               degenerate;
  } out_t;

  // Data that rides alongside the arithmetic through the cell chains.
  typedef struct packed {
    logic [47:0] ray_dir;
    logic [47:0] axis;
    logic        plane;
    logic        degen;
    logic [2:0]  neg;
  } side_t;

  typedef struct packed {
    logic                       valid;
    logic [ROOT_W-1:0]          v;
    logic [ROOT_W-1:0]          r;
    logic [ROOT_W-1:0]          b;
    logic [2:0][DIFF_BITS-1:0]  mag;
    side_t                      side;
  } sq_t;

  typedef struct packed {
    logic                      valid;
    logic [2:0][DIV_W-1:0]     rem;
    logic [DIV_W-1:0]          dsh;
    logic [2:0][QUO_BITS-1:0]  q;
    side_t                     side;
  } dv_t;

endpackage

FILE: hw/rtl/snorm_sqrt_cell.sv
`timescale 1ns / 1ps
module snorm_sqrt_cell
  import snorm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sq_t  din,
  output sq_t  dout
);

  logic [ROOT_W-1:0] trial;
  sq_t               nxt;

  // One result bit of the square root: try to subtract the current trial.
  always_comb begin
    trial = din.r + din.b;
    nxt   = din;
    if (din.v >= trial) begin
      nxt.v = din.v - trial;
      nxt.r = (din.r >> 1) + din.b;
    end else begin
      nxt.r = din.r >> 1;
    end
    nxt.b = din.b >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/snorm_div_cell.sv
`timescale 1ns / 1ps
module snorm_div_cell
  import snorm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  dv_t  din,
  output dv_t  dout
);

  dv_t nxt;

  // One quotient bit for each of the three components, shared divisor.
  always_comb begin
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      if (din.rem[i] >= din.dsh) begin
        nxt.rem[i] = din.rem[i] - din.dsh;
        nxt.q[i]   = {din.q[i][QUO_BITS-2:0], 1'b1};
      end else begin
        nxt.q[i]   = {din.q[i][QUO_BITS-2:0], 1'b0};
      end
    end
    nxt.dsh = din.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: hw/rtl/surface_normal_orient_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall  | in_data  (in_t)
// out     | output    | out_valid, out_stall| out_data (out_t)
//
// One transaction is accepted every cycle while in_stall is low.
// The depth is set by the square-root chain (31 cells) and the divider chain (16 cells).
// Reset clears every valid bit; no payload register is reset.
// A stalled output holds the whole pipeline, so in_stall follows out_valid and out_stall.
module surface_normal_orient_top
  import snorm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 0: offset from the centre and unpacked unit vectors.
  logic                        s0_valid;
  logic signed [DIFF_BITS-1:0] s0_d   [3];
  logic signed [UNIT_BITS-1:0] s0_ax  [3];
  logic [1:0]                  s0_kind;
  logic [47:0]                 s0_dir;
  logic [47:0]                 s0_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      s0_kind  <= in_data.object_kind;
      s0_dir   <= in_data.ray_dir;
      s0_axp   <= in_data.object_axis;
      for (int i = 0; i < 3; i++) begin
        s0_d[i]  <= $signed({in_data.hit_point[COORD_BITS*i+COORD_BITS-1],
                             in_data.hit_point[COORD_BITS*i +: COORD_BITS]})
                  - $signed({in_data.object_center[COORD_BITS*i+COORD_BITS-1],
                             in_data.object_center[COORD_BITS*i +: COORD_BITS]});
        s0_ax[i] <= $signed(in_data.object_axis[UNIT_BITS*i +: UNIT_BITS]);
      end
    end
  end

  // Stage 1: partial products of the axis projection.
  logic               s1_valid;
  logic signed [36:0] s1_dp [3];
  logic signed [DIFF_BITS-1:0] s1_d  [3];
  logic signed [UNIT_BITS-1:0] s1_ax [3];
  logic [1:0]         s1_kind;
  logic [47:0]        s1_dir;
  logic [47:0]        s1_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
      s1_kind  <= s0_kind;
      s1_dir   <= s0_dir;
      s1_axp   <= s0_axp;
      for (int i = 0; i < 3; i++) begin
        s1_dp[i] <= s0_d[i] * s0_ax[i];
        s1_d[i]  <= s0_d[i];
        s1_ax[i] <= s0_ax[i];
      end
    end
  end

  // Stage 2: projection length along the axis.
  logic               s2_valid;
  logic signed [38:0] s2_p;
  logic signed [DIFF_BITS-1:0] s2_d  [3];
  logic signed [UNIT_BITS-1:0] s2_ax [3];
  logic [1:0]         s2_kind;
  logic [47:0]        s2_dir;
  logic [47:0]        s2_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_kind  <= s1_kind;
      s2_dir   <= s1_dir;
      s2_axp   <= s1_axp;
      s2_p     <= 39'(s1_dp[0]) + 39'(s1_dp[1]) + 39'(s1_dp[2]);
      for (int i = 0; i < 3; i++) begin
        s2_d[i]  <= s1_d[i];
        s2_ax[i] <= s1_ax[i];
      end
    end
  end

  // Stage 3: projection vector, still at full precision.
  logic               s3_valid;
  logic signed [54:0] s3_prod [3];
  logic signed [DIFF_BITS-1:0] s3_d [3];
  logic [1:0]         s3_kind;
  logic [47:0]        s3_dir;
  logic [47:0]        s3_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_kind  <= s2_kind;
      s3_dir   <= s2_dir;
      s3_axp   <= s2_axp;
      for (int i = 0; i < 3; i++) begin
        s3_prod[i] <= 55'(s2_ax[i]) * 55'(s2_p);
        s3_d[i]    <= s2_d[i];
      end
    end
  end

  // Stage 4: round the projection, remove it and saturate; pick the vector.
  logic [54:0]                 pm   [3];
  logic [26:0]                 rnd  [3];
  logic signed [28:0]          pr   [3];
  logic signed [28:0]          rad  [3];
  logic signed [DIFF_BITS-1:0] e    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm[i]  = s3_prod[i][54] ? 55'(-s3_prod[i]) : 55'(s3_prod[i]);
      rnd[i] = 27'((pm[i] + (55'd1 << (2*UNIT_FRAC-1))) >> (2*UNIT_FRAC));
      pr[i]  = s3_prod[i][54] ? -$signed({2'b00, rnd[i]}) : $signed({2'b00, rnd[i]});
      rad[i] = 29'(s3_d[i]) - pr[i];
      if (rad[i] > 29'sd1048575)       e[i] = 21'sd1048575;
      else if (rad[i] < -29'sd1048576) e[i] = -21'sd1048576;
      else                             e[i] = rad[i][DIFF_BITS-1:0];
      if (s3_kind == KIND_SPHERE) e[i] = s3_d[i];
    end
  end

  logic                 s4_valid;
  logic [DIFF_BITS-1:0] s4_mag [3];
  logic [2:0]           s4_neg;
  logic                 s4_plane;
  logic [47:0]          s4_dir;
  logic [47:0]          s4_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
      s4_plane <= (s3_kind == KIND_PLANE);
      s4_dir   <= s3_dir;
      s4_axp   <= s3_axp;
      for (int i = 0; i < 3; i++) begin
        s4_neg[i] <= e[i][DIFF_BITS-1];
        s4_mag[i] <= e[i][DIFF_BITS-1] ? DIFF_BITS'(-e[i]) : DIFF_BITS'(e[i]);
      end
    end
  end

  // Stage 5: squared components.
  logic                 s5_valid;
  logic [41:0]          s5_sq  [3];
  logic [DIFF_BITS-1:0] s5_mag [3];
  logic [2:0]           s5_neg;
  logic                 s5_plane;
  logic [47:0]          s5_dir;
  logic [47:0]          s5_axp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
      s5_neg   <= s4_neg;
      s5_plane <= s4_plane;
      s5_dir   <= s4_dir;
      s5_axp   <= s4_axp;
      for (int i = 0; i < 3; i++) begin
        s5_sq[i]  <= 42'(s4_mag[i]) * 42'(s4_mag[i]);
        s5_mag[i] <= s4_mag[i];
      end
    end
  end

  // Stage 6: squared length, scaled, loaded into the square-root chain.
  logic [41:0] sum_sq;
  sq_t         sq_link [SQRT_CELLS+1];

  assign sum_sq = s5_sq[0] + s5_sq[1] + s5_sq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_link[0].valid <= 1'b0;
    end else if (en) begin
      sq_link[0].valid      <= s5_valid;
      sq_link[0].v          <= {1'b0, sum_sq, 20'd0};
      sq_link[0].r          <= '0;
      sq_link[0].b          <= ROOT_W'(1) << (2*(SQRT_CELLS-1));
      sq_link[0].mag        <= {s5_mag[2], s5_mag[1], s5_mag[0]};
      sq_link[0].side.ray_dir <= s5_dir;
      sq_link[0].side.axis  <= s5_axp;
      sq_link[0].side.plane <= s5_plane;
      sq_link[0].side.degen <= !s5_plane && (sum_sq == '0);
      sq_link[0].side.neg   <= s5_neg;
    end
  end

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    snorm_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq_link[k]),
      .dout (sq_link[k+1])
    );
  end

  // Divider load: rounded numerators over the length.
  logic [30:0] len;
  dv_t         dv_link [QUO_BITS+1];

  assign len = sq_link[SQRT_CELLS].r[30:0];

  always_comb begin
    dv_link[0].valid = sq_link[SQRT_CELLS].valid;
    dv_link[0].side  = sq_link[SQRT_CELLS].side;
    dv_link[0].dsh   = DIV_W'(len) << (QUO_BITS-1);
    dv_link[0].q     = '0;
    for (int i = 0; i < 3; i++) begin
      dv_link[0].rem[i] = (DIV_W'(sq_link[SQRT_CELLS].mag[i]) << (UNIT_FRAC+10))
                        + DIV_W'(len >> 1);
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    snorm_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dv_link[k]),
      .dout (dv_link[k+1])
    );
  end

  // Final stage A: cap, sign, choose the plane axis or zero a degenerate normal, and products with the ray.
  dv_t                          dq;
  logic [QUO_BITS-1:0]          qc [3];
  logic signed [UNIT_BITS-1:0]  nsel [3];

  assign dq = dv_link[QUO_BITS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq.q[i] > (QUO_BITS'(1) << UNIT_FRAC)) ? (QUO_BITS'(1) << UNIT_FRAC) : dq.q[i];
      if (dq.side.plane)       nsel[i] = $signed(dq.side.axis[UNIT_BITS*i +: UNIT_BITS]);
      else if (dq.side.degen)  nsel[i] = '0;
      else if (dq.side.neg[i]) nsel[i] = -$signed(qc[i]);
      else                     nsel[i] = $signed(qc[i]);
    end
  end

  logic                        f1_valid;
  logic signed [31:0]          f1_dp [3];
  logic signed [UNIT_BITS-1:0] f1_n  [3];
  logic                        f1_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= dq.valid;
      f1_degen <= dq.side.degen;
      for (int i = 0; i < 3; i++) begin
        f1_dp[i] <= $signed(dq.side.ray_dir[UNIT_BITS*i +: UNIT_BITS]) * nsel[i];
        f1_n[i]  <= nsel[i];
      end
    end
  end

  // Final stage B: orient against the ray, with saturation on negation.
  logic signed [33:0]          dot;
  logic                        flip;
  logic signed [UNIT_BITS:0]   negn [3];
  logic signed [UNIT_BITS-1:0] nout [3];

  always_comb begin
    dot  = 34'(f1_dp[0]) + 34'(f1_dp[1]) + 34'(f1_dp[2]);
    flip = !f1_degen && (dot > 34'sd0);
    for (int i = 0; i < 3; i++) begin
      negn[i] = -(17'(f1_n[i]));
      if (!flip)                   nout[i] = f1_n[i];
      else if (negn[i] > 17'sd32767) nout[i] = 16'sd32767;
      else                         nout[i] = negn[i][UNIT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid           <= f1_valid;
      out_data.normal_x   <= nout[0];
      out_data.normal_y   <= nout[1];
      out_data.normal_z   <= nout[2];
      out_data.flipped    <= flip;
      out_data.degenerate <= f1_degen;
    end
  end

`ifndef SYNTHESIS
  // The square-root remainder never exceeds twice the root.
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_link[SQRT_CELLS].valid |->
      (sq_link[SQRT_CELLS].v <= (sq_link[SQRT_CELLS].r << 1)))
    else $error("square-root remainder out of range");

  // Each divider remainder ends below the length, so never above twice the last divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dq.valid && !dq.side.degen && !dq.side.plane) |->
      (dq.rem[0] <= (dq.dsh << 1)) && (dq.rem[1] <= (dq.dsh << 1)) &&
      (dq.rem[2] <= (dq.dsh << 1)))
    else $error("divider remainder out of range");

  // A degenerate result carries a zero normal and is never flipped.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.normal_x == '0 && out_data.normal_y == '0 &&
       out_data.normal_z == '0 && !out_data.flipped))
    else $error("degenerate result not zero");

  // The input is held back only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
`endif

endmodule
